// ===== rtl/core/hmac_pkg.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA256 package
// Round constants, initial hash values, pads and state machine codes.
// ----------------------------------------------------------------------------
package hmac_pkg;

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5c;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_LOAD,
      ST_KEY_RUN,
      ST_ABSORB,
      ST_BLK_RUN,
      ST_PAD_FILL,
      ST_PAD_RUN,
      ST_INNER_SAVE,
      ST_OUT_FILL,
      ST_OUT_RUN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } core_ctl_type;

   localparam logic [255:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

// ===== rtl/core/hmac_round_core.sv =====
// ----------------------------------------------------------------------------
// HMAC SHA-256 round core
// Runs one compression over a 512-bit block, one round per cycle, with a
// 16-word rolling message schedule, then adds into the chain value.
// ----------------------------------------------------------------------------
module hmac_round_core (
   input  logic                  clock,
   input  logic                  reset,
   input  hmac_pkg::core_ctl_type ctl_in,
   output hmac_pkg::core_ctl_type ctl_out,
   input  logic [511:0]          block,
   input  logic [255:0]          chain_in,
   output logic [255:0]          chain_out
);
   import hmac_pkg::*;

   logic [511:0] w_ff, w_in;
   logic [255:0] v_ff, v_in, h_ff;
   logic [6:0]   rnd_ff, rnd_in;
   logic         busy_ff, done_ff;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   logic [31:0] a, b, c, d, e, f, g, h, w0, t1, t2, s0, s1, wn;

   always_comb begin
      {a, b, c, d, e, f, g, h} = v_ff;
      w0 = w_ff[511:480];
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(rnd_ff[5:0]) + w0;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(w_ff[479:448], 7) ^ rotr(w_ff[479:448], 18) ^ (w_ff[479:448] >> 3);
      s1 = rotr(w_ff[63:32], 17) ^ rotr(w_ff[63:32], 19) ^ (w_ff[63:32] >> 10);
      wn = w0 + s0 + w_ff[223:192] + s1;
      w_in = {w_ff[479:0], wn};
      v_in = {t1 + t2, a, b, c, d + t1, e, f, g};
      rnd_in = rnd_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl_in.start && !busy_ff) begin
            busy_ff <= 1'b1;
            rnd_ff <= '0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_in;
            if (rnd_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.start && !busy_ff) begin
         w_ff <= block;
         v_ff <= chain_in;
         h_ff <= chain_in;
      end else if (busy_ff) begin
         w_ff <= w_in;
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++)
         chain_out[i*32 +: 32] = h_ff[i*32 +: 32] + v_ff[i*32 +: 32];
      ctl_out.start = 1'b0;
      ctl_out.busy = busy_ff;
      ctl_out.done = done_ff;
   end
endmodule

// ===== rtl/core/hmac_sha256_engine_top.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA256 engine top level
// Byte-stream HMAC-SHA256 with a 64-byte key written as eight 64-bit words.
// ----------------------------------------------------------------------------
// A byte that does not fill the block is written into the buffer; a byte that
// fills it also starts a compression in the one shared round unit, which does
// one round a cycle. The first byte of a message is preceded by the key block.
// A final word adds three or four compressions, then eight result words, one
// per cycle as the consumer takes them. No new item is taken until idle. Reset is
// synchronous and active high; it clears the key, control and length state.
module hmac_sha256_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // message_byte[7:0]
   input  logic [1:0]  req_tuser,   // has_byte[0], final_item[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_index[34:32], zero fill
   output logic        rsp_tlast,   // last_word
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import hmac_pkg::*;

   state_type    state_ff, state_in;
   logic [511:0] key_ff;
   logic [511:0] buf_ff;       // block buffer, byte 0 in the top bits
   logic [255:0] chain_ff, inner_ff;
   logic [6:0]   fill_ff;
   logic [63:0]  len_ff;
   logic         open_ff, fin_ff, second_ff, outer_ff;
   logic [2:0]   widx_ff;
   logic [7:0]   byte_ff;
   logic         has_ff;

   core_ctl_type ctl_to, ctl_from;
   logic [511:0] core_blk;
   logic [255:0] core_out;

   hmac_round_core u_core (
      .clock(clock), .reset(reset), .ctl_in(ctl_to), .ctl_out(ctl_from),
      .block(core_blk), .chain_in(chain_ff), .chain_out(core_out));

   logic accept;
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (accept && (req_tuser[0] || req_tuser[1]))
               state_in = open_ff ? ST_ABSORB : ST_KEY_LOAD;
         ST_KEY_LOAD: state_in = ST_KEY_RUN;
         ST_KEY_RUN:  if (ctl_from.done) state_in = ST_ABSORB;
         ST_ABSORB:
            if (has_ff && fill_ff == 7'd63) state_in = ST_BLK_RUN;
            else if (fin_ff) state_in = ST_PAD_FILL;
            else state_in = ST_IDLE;
         ST_BLK_RUN:  if (ctl_from.done) state_in = fin_ff ? ST_PAD_FILL : ST_IDLE;
         ST_PAD_FILL: state_in = ST_PAD_RUN;
         ST_PAD_RUN:
            if (ctl_from.done) begin
               if (second_ff) state_in = ST_PAD_FILL;
               else state_in = outer_ff ? ST_EMIT : ST_INNER_SAVE;
            end
         ST_INNER_SAVE: state_in = ST_OUT_FILL;
         ST_OUT_FILL: state_in = ST_OUT_RUN;
         ST_OUT_RUN:  if (ctl_from.done) state_in = ST_PAD_FILL;
         ST_EMIT:     if (rsp_tready && widx_ff == 3'd7) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl_to = '0;
      ctl_to.start = (state_ff == ST_KEY_LOAD) || (state_ff == ST_PAD_FILL)
                     || (state_ff == ST_OUT_FILL)
                     || (state_ff == ST_ABSORB && has_ff && fill_ff == 7'd63);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tdata = {5'd0, widx_ff, chain_ff[255 - 32*widx_ff -: 32]};
      rsp_tlast = (widx_ff == 3'd7);
   end

   // Key registers.
   always_ff @(posedge clock) begin
      if (reset) key_ff <= '0;
      else if (csr_we) key_ff[511 - 64*csr_index -: 64] <= csr_wdata;
   end

   logic [511:0] buf_byte;
   always_comb begin
      buf_byte = buf_ff;
      buf_byte[511 - 8*fill_ff[5:0] -: 8] = byte_ff;
   end

   logic [511:0] pad_blk;
   logic         pad_two;
   always_comb begin
      pad_blk = buf_ff;
      pad_blk[511 - 8*fill_ff[5:0] -: 8] = PAD_MARK;
      for (int j = 0; j < 64; j++)
         if (j > fill_ff) pad_blk[511 - 8*j -: 8] = 8'h00;
      pad_two = (fill_ff > 7'd55);
      if (!pad_two) pad_blk[63:0] = len_ff;
   end

   // The core takes its block at the start edge. A block that is completed in
   // that same cycle (the last byte of a full block, or a padding block) is
   // fed straight from the builder rather than from the buffer.
   always_comb begin
      unique case (state_ff)
         ST_ABSORB:   core_blk = buf_byte;
         ST_PAD_FILL: core_blk = second_ff ? {448'd0, len_ff} : pad_blk;
         default:     core_blk = buf_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= INIT_HASH;
         fill_ff <= '0;
         len_ff <= '0;
         open_ff <= 1'b0;
         fin_ff <= 1'b0;
         has_ff <= 1'b0;
         second_ff <= 1'b0;
         outer_ff <= 1'b0;
         widx_ff <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               byte_ff <= req_tdata;
               has_ff <= req_tuser[0];
               fin_ff <= req_tuser[1];
               if (!open_ff && (req_tuser[0] || req_tuser[1])) begin
                  open_ff <= 1'b1;
                  outer_ff <= 1'b0;
                  chain_ff <= INIT_HASH;
                  len_ff <= 64'd512;
                  fill_ff <= '0;
                  for (int j = 0; j < 64; j++) buf_ff[511 - 8*j -: 8] <=
                     key_ff[511 - 8*j -: 8] ^ IPAD;
               end
            end
            ST_KEY_RUN: if (ctl_from.done) chain_ff <= core_out;
            ST_ABSORB: if (has_ff) begin
               buf_ff <= buf_byte;
               len_ff <= len_ff + 64'd8;
               fill_ff <= (fill_ff == 7'd63) ? 7'd0 : fill_ff + 7'd1;
            end
            ST_BLK_RUN: if (ctl_from.done) chain_ff <= core_out;
            ST_PAD_FILL: begin
               if (second_ff) begin
                  buf_ff <= {448'd0, len_ff};
                  second_ff <= 1'b0;
               end else begin
                  buf_ff <= pad_blk;
                  second_ff <= pad_two;
               end
               fill_ff <= '0;
            end
            ST_PAD_RUN: if (ctl_from.done) chain_ff <= core_out;
            ST_INNER_SAVE: begin
               inner_ff <= chain_ff;
               chain_ff <= INIT_HASH;
               outer_ff <= 1'b1;
               for (int j = 0; j < 64; j++) buf_ff[511 - 8*j -: 8] <=
                  key_ff[511 - 8*j -: 8] ^ OPAD;
            end
            ST_OUT_RUN: if (ctl_from.done) begin
               chain_ff <= core_out;
               buf_ff <= {inner_ff, 256'd0};
               fill_ff <= 7'd32;
               len_ff <= 64'd768;
            end
            ST_EMIT: if (rsp_tready) begin
               widx_ff <= widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  open_ff <= 1'b0;
                  outer_ff <= 1'b0;
                  fill_ff <= '0;
                  len_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
